@@ hw/rtl/tpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tpt_pkg
// Types, codes and reset values shared by the touch point tracker modules.
// ----------------------------------------------------------------------------
package tpt_pkg;

  localparam int unsigned NUM_SLOTS = 5;

  localparam logic [15:0] NONE_COORD = 16'hFFFF;
  localparam logic [7:0]  NONE_ID    = 8'hFF;
  localparam logic [7:0]  NO_FREE_ID = 8'h00;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [1:0]  RST_DIRECTION = 2'd3;
  localparam logic [15:0] RST_WIDTH     = 16'd800;
  localparam logic [15:0] RST_HEIGHT    = 16'd480;
  localparam logic [7:0]  RST_MATCH     = 8'd10;

  typedef enum logic [1:0] {
    PHASE_UP   = 2'd0,
    PHASE_DOWN = 2'd1,
    PHASE_MOVE = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } direction_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION = 4'd0,
    CFG_WIDTH     = 4'd1,
    CFG_HEIGHT    = 4'd2,
    CFG_MATCH     = 4'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_FREE,
    ST_DONE
  } tpt_state_e;

  typedef struct packed {
    logic [7:0]  finger_count;
    logic [2:0]  slot_index;
    logic [11:0] raw_x;
    logic [11:0] raw_y;
  } tpt_in_t;

  typedef struct packed {
    logic [2:0]  out_slot;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [1:0]  phase;
    logic [7:0]  touch_id;
  } tpt_out_t;

  // one slot entry, as written back into the slot file
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [1:0]  phase;
    logic [7:0]  id;
  } slot_wr_t;

endpackage

@@ hw/rtl/tpt_match_unit.sv @@
// ----------------------------------------------------------------------------
// tpt_match_unit
// Shared proximity compare: both axes strictly closer than the match distance.
// ----------------------------------------------------------------------------
module tpt_match_unit import tpt_pkg::*; (
  input  logic [15:0] new_x_i,
  input  logic [15:0] new_y_i,
  input  logic [15:0] old_x_i,
  input  logic [15:0] old_y_i,
  input  logic [7:0]  distance_i,
  output logic        hit_o
);

  logic [15:0] diff_x;
  logic [15:0] diff_y;

  always_comb begin
    diff_x = (new_x_i >= old_x_i) ? (new_x_i - old_x_i) : (old_x_i - new_x_i);
    diff_y = (new_y_i >= old_y_i) ? (new_y_i - old_y_i) : (old_y_i - new_y_i);
    hit_o  = (diff_x < {8'd0, distance_i}) && (diff_y < {8'd0, distance_i});
  end

endmodule

@@ hw/rtl/tpt_slot_file.sv @@
// ----------------------------------------------------------------------------
// tpt_slot_file
// Per-slot point, phase and id registers with a scan read port, a current-slot
// phase read, an id-in-use check and one write port.
// ----------------------------------------------------------------------------
module tpt_slot_file import tpt_pkg::*; #(
  parameter int unsigned SLOT_COUNT = NUM_SLOTS,
  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [IW-1:0] scan_idx_i,
  output logic [15:0]   scan_x_o,
  output logic [15:0]   scan_y_o,
  output logic [7:0]    scan_id_o,
  input  logic [IW-1:0] cur_idx_i,
  output logic [1:0]    cur_phase_o,
  input  logic [CW-1:0] cand_i,
  output logic          cand_used_o,
  input  logic          wr_en_i,
  input  slot_wr_t      wr_i
);

  logic [15:0] x_q     [SLOT_COUNT];
  logic [15:0] y_q     [SLOT_COUNT];
  logic [1:0]  phase_q [SLOT_COUNT];
  logic [7:0]  id_q    [SLOT_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
        x_q[k]     <= NONE_COORD;
        y_q[k]     <= NONE_COORD;
        phase_q[k] <= PHASE_UP;
        id_q[k]    <= NONE_ID;
      end
    end else if (wr_en_i) begin
      x_q[cur_idx_i]     <= wr_i.x;
      y_q[cur_idx_i]     <= wr_i.y;
      phase_q[cur_idx_i] <= wr_i.phase;
      id_q[cur_idx_i]    <= wr_i.id;
    end
  end

  assign scan_x_o    = x_q[scan_idx_i];
  assign scan_y_o    = y_q[scan_idx_i];
  assign scan_id_o   = id_q[scan_idx_i];
  assign cur_phase_o = phase_q[cur_idx_i];

  // the current slot's own id counts as released during the free-id search
  always_comb begin
    cand_used_o = 1'b0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if ((IW'(k) != cur_idx_i) && (id_q[k] == 8'(cand_i))) begin
        cand_used_o = 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/touch_point_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// touch_point_tracker_unit
// Tracks touch slots from controller slot reports and assigns tracking ids.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one slot report
// per transaction; output channel (out_valid_o / out_stall_i / out_data_o)
// returns the slot's new contents, one result per in-range report. Reports
// for a slot index at or above SLOT_COUNT are taken and dropped.
// Path from acceptance to the result register: an inactive slot goes straight
//   to the final step; an active slot first scans the stored slots through
//   the one match compare unit (one slot a cycle) and then, if needed, runs
//   the free-id search (one candidate id a cycle). The next report is taken
//   in the cycle after the result is loaded.
// The input stalls while a report is in work; it is taken again as soon as
// the result is loaded, even while that result waits in the output register.
// A stalled result holds, and the next report then waits in its final step.
// Configuration writes (cfg_valid_i / cfg_ready_o) are always accepted. The user
// must issue them only while the block is idle; the block does not enforce it.
// Reset clears all slots to no point, up phase, no id, and loads the default
// configuration; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module touch_point_tracker_unit import tpt_pkg::*; #(
  parameter int unsigned SLOT_COUNT = NUM_SLOTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  tpt_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output tpt_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);

  tpt_state_e state_q, state_d;

  logic [1:0]  dir_q;
  logic [15:0] width_q, height_q;
  logic [7:0]  dist_q;

  logic [2:0]    slot_q, slot_d;
  logic          active_q, active_d;
  logic [15:0]   px_q, px_d, py_q, py_d;
  logic [IW-1:0] scan_q, scan_d;
  logic [CW-1:0] cand_q, cand_d;
  logic [7:0]    id_q, id_d;

  logic     out_valid_q, out_valid_d;
  tpt_out_t out_q, out_d;

  logic [15:0] scan_x, scan_y;
  logic [7:0]  scan_id;
  logic [1:0]  cur_phase;
  logic        cand_used;
  logic        hit;
  logic        wr_en;
  slot_wr_t    wr;

  logic        in_take;
  logic        in_range, in_active;
  logic [15:0] big_side, small_side;
  logic [1:0]  next_phase;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q    <= RST_DIRECTION;
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      dist_q   <= RST_MATCH;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DIRECTION: dir_q    <= cfg_data_i[1:0];
        CFG_WIDTH:     width_q  <= cfg_data_i;
        CFG_HEIGHT:    height_q <= cfg_data_i;
        CFG_MATCH:     dist_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- units
  tpt_slot_file #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_slots (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scan_idx_i  (scan_q),
    .scan_x_o    (scan_x),
    .scan_y_o    (scan_y),
    .scan_id_o   (scan_id),
    .cur_idx_i   (IW'(slot_q)),
    .cur_phase_o (cur_phase),
    .cand_i      (cand_q),
    .cand_used_o (cand_used),
    .wr_en_i     (wr_en),
    .wr_i        (wr)
  );

  tpt_match_unit u_match (
    .new_x_i    (px_q),
    .new_y_i    (py_q),
    .old_x_i    (scan_x),
    .old_y_i    (scan_y),
    .distance_i (dist_q),
    .hit_o      (hit)
  );

  // ---------------------------------------------------------------- intake
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_range   = (32'(in_data_i.slot_index) < 32'(SLOT_COUNT));
    // counts above the slot count read as no fingers
    in_active  = (32'(in_data_i.finger_count) <= 32'(SLOT_COUNT)) &&
                 ({5'd0, in_data_i.slot_index} < in_data_i.finger_count);
    big_side   = (width_q > height_q) ? width_q : height_q;
    small_side = (width_q < height_q) ? width_q : height_q;
  end

  always_comb begin
    unique case (cur_phase)
      PHASE_UP:   next_phase = PHASE_DOWN;
      PHASE_DOWN: next_phase = PHASE_MOVE;
      default:    next_phase = cur_phase;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    active_q <= active_d;
    px_q     <= px_d;
    py_q     <= py_d;
    scan_q   <= scan_d;
    cand_q   <= cand_d;
    id_q     <= id_d;
    out_q    <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    active_d    = active_q;
    px_d        = px_q;
    py_d        = py_q;
    scan_d      = scan_q;
    cand_d      = cand_q;
    id_d        = id_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    wr_en       = 1'b0;
    wr.x        = active_q ? px_q : NONE_COORD;
    wr.y        = active_q ? py_q : NONE_COORD;
    wr.phase    = active_q ? next_phase : PHASE_UP;
    wr.id       = active_q ? id_q : NONE_ID;

    unique case (state_q)
      ST_IDLE: begin
        if (in_take && in_range) begin
          slot_d   = in_data_i.slot_index;
          active_d = in_active;
          scan_d   = '0;
          cand_d   = CW'(1);
          unique case (in_data_i.finger_count == 8'd0 ? DIR_UP : direction_e'(dir_q))
            DIR_LEFT: begin
              px_d = big_side - {4'd0, in_data_i.raw_y};
              py_d = small_side - {4'd0, in_data_i.raw_x};
            end
            DIR_RIGHT: begin
              px_d = {4'd0, in_data_i.raw_y};
              py_d = {4'd0, in_data_i.raw_x};
            end
            default: begin
              px_d = NONE_COORD;
              py_d = NONE_COORD;
            end
          endcase
          state_d = in_active ? ST_MATCH : ST_DONE;
        end
      end
      ST_MATCH: begin
        if (hit) begin
          id_d    = scan_id;
          state_d = (scan_id == NONE_ID) ? ST_FREE : ST_DONE;
        end else if (scan_q == IW'(SLOT_COUNT - 1)) begin
          state_d = ST_FREE;
        end else begin
          scan_d = scan_q + IW'(1);
        end
      end
      ST_FREE: begin
        if (!cand_used) begin
          id_d    = 8'(cand_q);
          state_d = ST_DONE;
        end else if (cand_q == CW'(SLOT_COUNT)) begin
          id_d    = NO_FREE_ID;
          state_d = ST_DONE;
        end else begin
          cand_d = cand_q + CW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          wr_en          = 1'b1;
          out_valid_d    = 1'b1;
          out_d.out_slot = slot_q;
          out_d.pos_x    = wr.x;
          out_d.pos_y    = wr.y;
          out_d.phase    = wr.phase;
          out_d.touch_id = wr.id;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------- checks
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result loaded outside the final step");

  a_cand_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FREE |-> (cand_q != '0) && (32'(cand_q) <= 32'(SLOT_COUNT)))
    else $error("free-id candidate out of range");

  a_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.touch_id == NONE_ID) ||
                    (32'(out_q.touch_id) <= 32'(SLOT_COUNT)))
    else $error("tracking id out of range");

  a_inactive_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.touch_id == NONE_ID) |-> out_q.phase == PHASE_UP)
    else $error("cleared slot reports a touch phase");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for touch_point_tracker_unit. A directed table covers the field
// extremes, inactive and ignored slots, id matching and each rotation; then
// framed slot reports with random coordinates and some noise run under
// several register settings. Every result is checked, in order, against the
// table's expected value where it gives one, else a local model of the slot file.
// ----------------------------------------------------------------------------
module tb_top import tpt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned NUM_CFG_REGS    = 4;
  localparam int unsigned DRAIN_CYCLES    = 2 * NUM_SLOTS + 10;
  localparam int unsigned LONG_HOLD       = 300;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  typedef enum logic {
    ROW_REPORT,
    ROW_CONFIG
  } row_kind_e;

  typedef struct {
    row_kind_e             kind;
    tpt_in_t               item;
    bit                    known;
    tpt_out_t              result;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  tpt_in_t               in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  tpt_out_t              out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // model of the slot file and registers
  logic [15:0] trk_x [NUM_SLOTS];
  logic [15:0] trk_y [NUM_SLOTS];
  phase_e      trk_phase [NUM_SLOTS];
  logic [7:0]  trk_id [NUM_SLOTS];
  direction_e  cur_dir;
  logic [15:0] cur_width;
  logic [15:0] cur_height;
  logic [7:0]  cur_match;

  tpt_out_t    pending_points [$];
  row_t        directed_rows [$];
  logic [11:0] last_rx [NUM_SLOTS];
  logic [11:0] last_ry [NUM_SLOTS];

  int unsigned failures  = 0;
  int unsigned placed    = 0;
  bit          no_idle   = 1'b0;
  bit          hold_armed = 1'b0;
  bit          hold_done = 1'b0;
  bit          holding   = 1'b0;
  tpt_out_t    want;

  touch_point_tracker_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [15:0] axis_gap(input logic [15:0] a, input logic [15:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // one slot report applied to the slot file; returns the slot's new contents
  function automatic tpt_out_t track_report(input tpt_in_t rep);
    int unsigned count;
    int unsigned s;
    int unsigned k;
    int unsigned cand;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  id;
    bit          found;
    bit          used;
    tpt_out_t    res;
    count = 32'(rep.finger_count);
    if (count > NUM_SLOTS) count = 0;
    s = 32'(rep.slot_index);
    if (s < count) begin
      case (cur_dir)
        DIR_LEFT: begin
          w  = (cur_width > cur_height) ? cur_width : cur_height;
          h  = (cur_width < cur_height) ? cur_width : cur_height;
          px = w - {4'd0, rep.raw_y};
          py = h - {4'd0, rep.raw_x};
        end
        DIR_RIGHT: begin
          px = {4'd0, rep.raw_y};
          py = {4'd0, rep.raw_x};
        end
        default: begin
          px = NONE_COORD;
          py = NONE_COORD;
        end
      endcase
      if (trk_phase[s] == PHASE_UP) trk_phase[s] = PHASE_DOWN;
      else if (trk_phase[s] == PHASE_DOWN) trk_phase[s] = PHASE_MOVE;
      id    = NONE_ID;
      found = 1'b0;
      for (k = 0; k < NUM_SLOTS; k++) begin
        if (!found && axis_gap(px, trk_x[k]) < {8'd0, cur_match} &&
            axis_gap(py, trk_y[k]) < {8'd0, cur_match}) begin
          id    = trk_id[k];
          found = 1'b1;
        end
      end
      trk_id[s] = id;
      // own previous id is released before the free-id search
      if (id == NONE_ID) begin
        id    = NO_FREE_ID;
        found = 1'b0;
        for (cand = 1; cand <= NUM_SLOTS; cand++) begin
          used = 1'b0;
          for (k = 0; k < NUM_SLOTS; k++)
            if (trk_id[k] == cand[7:0]) used = 1'b1;
          if (!used && !found) begin
            id    = cand[7:0];
            found = 1'b1;
          end
        end
        trk_id[s] = id;
      end
      trk_x[s] = px;
      trk_y[s] = py;
    end else begin
      trk_x[s]     = NONE_COORD;
      trk_y[s]     = NONE_COORD;
      trk_phase[s] = PHASE_UP;
      trk_id[s]    = NONE_ID;
    end
    res.out_slot = s[2:0];
    res.pos_x    = trk_x[s];
    res.pos_y    = trk_y[s];
    res.phase    = trk_phase[s];
    res.touch_id = trk_id[s];
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [11:0] nudge(input logic [11:0] v);
    int d;
    int n;
    d = int'(cur_match);
    n = int'(v) + int'($urandom_range(0, 2 * d)) - d;
    if (n < 0) n = 0;
    if (n > 4095) n = 4095;
    return n[11:0];
  endfunction

  task automatic add_report(input int unsigned cnt, input int unsigned slot,
                            input int unsigned rx, input int unsigned ry);
    row_t row;
    row.kind              = ROW_REPORT;
    row.item.finger_count = cnt[7:0];
    row.item.slot_index   = slot[2:0];
    row.item.raw_x        = rx[11:0];
    row.item.raw_y        = ry[11:0];
    row.known             = 1'b0;
    row.result            = '0;
    row.idx               = '0;
    row.data              = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_known(input int unsigned cnt, input int unsigned slot,
                           input int unsigned rx, input int unsigned ry,
                           input logic [15:0] x, input logic [15:0] y,
                           input phase_e ph, input logic [7:0] id);
    add_report(cnt, slot, rx, ry);
    directed_rows[$].known           = 1'b1;
    directed_rows[$].result.out_slot = slot[2:0];
    directed_rows[$].result.pos_x    = x;
    directed_rows[$].result.pos_y    = y;
    directed_rows[$].result.phase    = ph;
    directed_rows[$].result.touch_id = id;
  endtask

  task automatic add_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    row_t row;
    row.kind   = ROW_CONFIG;
    row.item   = '0;
    row.known  = 1'b0;
    row.result = '0;
    row.idx    = idx;
    row.data   = data;
    directed_rows.push_back(row);
  endtask

  task automatic send_report(input tpt_in_t item, input bit known, input tpt_out_t known_res);
    int unsigned gap;
    tpt_out_t    res;
    in_data_i  <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (32'(item.slot_index) < NUM_SLOTS) begin
      res = track_report(item);
      pending_points.push_back(known ? known_res : res);
      placed++;
    end
    gap = holding ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // leaves valid high when another write follows in the next cycle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                           input bit more);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (!more) cfg_valid_i <= 1'b0;
    case (idx)
      CFG_DIRECTION: cur_dir = direction_e'(data[1:0]);
      CFG_WIDTH:     cur_width = data;
      CFG_HEIGHT:    cur_height = data;
      CFG_MATCH:     cur_match = data[7:0];
      default: ;
    endcase
  endtask

  // wait until all results are back and any dropped report has left the block
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // one report per slot, same finger count, points mostly near the last ones
  task automatic run_frame();
    tpt_in_t     item;
    int unsigned n;
    int unsigned s;
    tpt_out_t    unused_res;
    unused_res = '0;
    n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, NUM_SLOTS);
    item.finger_count = n[7:0];
    if (n == 0 && $urandom_range(0, 1) == 1) item.finger_count = 8'($urandom_range(6, 255));
    for (s = 0; s < NUM_SLOTS; s++) begin
      item.slot_index = s[2:0];
      if ($urandom_range(0, 4) == 0) begin
        last_rx[s] = 12'($urandom_range(0, 4095));
        last_ry[s] = 12'($urandom_range(0, 4095));
      end else begin
        last_rx[s] = nudge(last_rx[s]);
        last_ry[s] = nudge(last_ry[s]);
      end
      item.raw_x = last_rx[s];
      item.raw_y = last_ry[s];
      send_report(item, 1'b0, unused_res);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp, input logic [15:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_points.size() == 0) begin
        $display("%0t: result for slot %0d with no report pending, got %0h",
                 $time, out_data_o.out_slot, out_data_o);
        failures++;
      end else begin
        want = pending_points.pop_front();
        check_field("out_slot", 16'(want.out_slot), 16'(out_data_o.out_slot));
        check_field("pos_x", want.pos_x, out_data_o.pos_x);
        check_field("pos_y", want.pos_y, out_data_o.pos_y);
        check_field("phase", 16'(want.phase), 16'(out_data_o.phase));
        check_field("touch_id", 16'(want.touch_id), 16'(out_data_o.touch_id));
      end
    end
  end

  // output side: random stall stretches, plus one long hold-off
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (hold_armed && !hold_done) begin
        out_stall_i <= 1'b1;
        holding = 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        holding   = 1'b0;
        hold_done = 1'b1;
      end else begin
        gap = pick_gap();
        if (gap != 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int unsigned           i;
    int unsigned           ph;
    row_t                  row;
    tpt_in_t               item;
    tpt_out_t              unused_res;
    logic [CFG_DATA_W-1:0] data;
    int unsigned           r;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    unused_res  = '0;
    for (i = 0; i < NUM_SLOTS; i++) begin
      trk_x[i]     = NONE_COORD;
      trk_y[i]     = NONE_COORD;
      trk_phase[i] = PHASE_UP;
      trk_id[i]    = NONE_ID;
      last_rx[i]   = 12'($urandom_range(0, 4095));
      last_ry[i]   = 12'($urandom_range(0, 4095));
    end
    cur_dir    = direction_e'(RST_DIRECTION);
    cur_width  = RST_WIDTH;
    cur_height = RST_HEIGHT;
    cur_match  = RST_MATCH;

    // reset settings: right rotation, 800x480, match distance 10
    add_known(1, 0, 0, 0, 16'd0, 16'd0, PHASE_DOWN, 8'd1);
    add_known(1, 0, 4095, 4095, 16'd4095, 16'd4095, PHASE_MOVE, 8'd1);
    add_known(1, 1, 4095, 0, NONE_COORD, NONE_COORD, PHASE_UP, NONE_ID);
    add_report(5, 1, 4090, 4090);
    add_report(5, 2, 100, 200);
    add_report(5, 3, 109, 191);
    add_report(5, 4, 110, 190);
    add_known(255, 4, 1, 1, NONE_COORD, NONE_COORD, PHASE_UP, NONE_ID);
    add_known(6, 3, 2, 2, NONE_COORD, NONE_COORD, PHASE_UP, NONE_ID);
    add_report(5, 5, 10, 10);
    add_report(5, 6, 4095, 4095);
    add_report(7, 7, 0, 0);
    add_known(0, 0, 4095, 4095, NONE_COORD, NONE_COORD, PHASE_UP, NONE_ID);
    // left rotation, wrap on the y axis
    add_config(CFG_DIRECTION, {14'h3FFF, DIR_LEFT});
    add_config(CFG_WIDTH, 16'd0);
    add_config(CFG_HEIGHT, 16'hFFFF);
    add_config(CFG_MATCH, 16'hFF00 | 16'd255);
    add_config(4'hF, 16'hFFFF);
    add_report(2, 0, 0, 0);
    add_report(2, 1, 4095, 4095);
    // no coordinates: first match is a cleared slot, then a slot with a real id
    add_config(CFG_DIRECTION, {14'd0, DIR_UP});
    add_config(CFG_MATCH, 16'd1);
    add_report(3, 2, 7, 7);
    add_report(3, 0, 8, 8);
    add_config(CFG_DIRECTION, {14'd0, DIR_DOWN});
    add_config(CFG_WIDTH, 16'hFFFF);
    add_config(CFG_HEIGHT, 16'd0);
    add_report(4, 3, 4095, 0);
    add_config(CFG_DIRECTION, {14'd0, DIR_RIGHT});
    add_config(CFG_WIDTH, RST_WIDTH);
    add_config(CFG_HEIGHT, RST_HEIGHT);
    add_config(CFG_MATCH, {8'd0, RST_MATCH});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < directed_rows.size(); i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_CONFIG) begin
        if (i == 0 || directed_rows[i-1].kind != ROW_CONFIG) settle_block();
        write_reg(row.idx, row.data,
                  i + 1 < directed_rows.size() && directed_rows[i+1].kind == ROW_CONFIG);
      end else begin
        send_report(row.item, row.known, row.result);
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        settle_block();
        r = $urandom_range(0, 9);
        data = 16'($urandom);
        data[1:0] = (r < 4) ? DIR_LEFT : (r < 8) ? DIR_RIGHT : (r == 8) ? DIR_UP : DIR_DOWN;
        write_reg(CFG_IDX_W'($urandom_range(NUM_CFG_REGS, 2 ** CFG_IDX_W - 1)),
                  CFG_DATA_W'($urandom), 1'b1);
        write_reg(CFG_DIRECTION, data, 1'b1);
        r = $urandom_range(0, 4);
        data = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom);
        write_reg(CFG_WIDTH, data, 1'b1);
        r = $urandom_range(0, 4);
        data = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom);
        write_reg(CFG_HEIGHT, data, 1'b1);
        r = $urandom_range(0, 9);
        data = 16'($urandom);
        data[7:0] = (r == 0) ? 8'd1 : (r == 1) ? 8'd255 : 8'($urandom_range(1, 64));
        write_reg(CFG_MATCH, data, 1'b0);
      end
      no_idle = (ph % 3 == 2);
      if (ph == 0) hold_armed = 1'b1;
      placed = 0;
      while (placed < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 4) != 0) begin
          run_frame();
        end else begin
          item.finger_count = 8'($urandom_range(0, 255));
          item.slot_index   = 3'($urandom_range(0, 7));
          item.raw_x        = 12'($urandom_range(0, 4095));
          item.raw_y        = 12'($urandom_range(0, 4095));
          send_report(item, 1'b0, unused_res);
        end
      end
    end

    settle_block();
    if (failures == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tpt_pkg.sv
hw/rtl/tpt_match_unit.sv
hw/rtl/tpt_slot_file.sv
hw/rtl/touch_point_tracker_unit.sv
dv/tb_top.sv
